// ===== rtl/msvgs_pkg.sv =====
// Shared constants, command codes and status types for the gap selection block.
package msvgs_pkg;

  localparam int MAX_ITEMS_DEF = 1024;
  localparam int VALUE_W       = 30;
  localparam int TOTAL_W       = 41;
  localparam int GAP           = 2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_INS_START,
    OP_INS_SHIFT,
    OP_INS_PUT,
    OP_GRP_START,
    OP_GRP_STEP,
    OP_GRP_FLUSH,
    OP_DP_RDI,
    OP_DP_TRRD,
    OP_DP_TRSTEP,
    OP_DP_SUM,
    OP_FINISH
  } op_t;

  typedef struct packed {
    logic full;
    logic last;
    logic j_zero;
    logic j_one;
    logic gt;
    logic i_done;
    logic adv;
    logic dp_last;
    logic out_busy;
  } status_t;

endpackage

// ===== rtl/msvgs_if.sv =====
// Valid/ready channel interfaces for input items and results.
interface msvgs_in_if;
  import msvgs_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [VALUE_W-1:0]   power_value;
  logic                 last_item;
  modport source (output valid, output power_value, output last_item, input ready);
  modport sink   (input valid, input power_value, input last_item, output ready);
endinterface

interface msvgs_out_if;
  import msvgs_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [TOTAL_W-1:0]   best_total;
  modport source (output valid, output best_total, input ready);
  modport sink   (input valid, input best_total, output ready);
endinterface

// ===== rtl/max_sum_value_gap_selection.sv =====
// Top level of the gap-of-two best total block.
// Usage: values arrive on in_ch (valid/ready), one per transfer, with last_item
// set on the final value of a set. Each value is placed into sorted order in
// the value memory as it arrives: every stored value larger than it is moved
// up one place through the single read port of the value memory before it is
// written, and in_ch is not ready again until it is in place.
// Values beyond MAX_ITEMS are dropped.
// After the last value the stored set is merged into groups of equal value,
// then the program visits each group in turn, advancing the trailing index
// at most groups - 1 times in total. One transfer on out_ch
// then carries best_total; in_ch is ready again in the same cycle the result
// is loaded, so a new set may start while the result still waits. If out_ch
// stalls with a result held, a later result waits in the block until the
// held one is taken. Reset (rst_n low, synchronous) empties the set and
// drops any pending result; memories need no clearing.
module max_sum_value_gap_selection #(
  parameter int MAX_ITEMS = msvgs_pkg::MAX_ITEMS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  msvgs_in_if.sink    in_ch,
  msvgs_out_if.source out_ch
);
  import msvgs_pkg::*;

  op_t     op;
  status_t st;

  msvgs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .st(st), .op(op)
  );

  msvgs_dp #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
    .clk(clk), .rst_n(rst_n), .op(op),
    .in_value(in_ch.power_value), .in_last(in_ch.last_item),
    .out_ready(out_ch.ready), .out_valid(out_ch.valid), .out_total(out_ch.best_total),
    .st(st)
  );

endmodule

// ===== rtl/msvgs_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module msvgs_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/msvgs_ctrl.sv =====
// Controller state machine sequencing load, insertion, grouping and the program.
module msvgs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  msvgs_pkg::status_t st,
  output msvgs_pkg::op_t    op
);
  import msvgs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_INS,
    S_SHIFT,
    S_PUT,
    S_GRP0,
    S_GRP,
    S_FLUSH,
    S_RDI,
    S_TRRD,
    S_TRSTEP,
    S_SUM,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  state_t after_ins;

  assign in_ready  = (state_r == S_IDLE);
  assign after_ins = st.last ? S_GRP0 : S_IDLE;

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = OP_LOAD;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD:  state_nxt = st.full ? after_ins : S_INS;
      S_INS: begin
        op        = OP_INS_START;
        state_nxt = st.j_zero ? after_ins : S_SHIFT;
      end
      S_SHIFT: begin
        op = OP_INS_SHIFT;
        if (st.gt) begin
          state_nxt = st.j_one ? S_PUT : S_SHIFT;
        end else begin
          state_nxt = after_ins;
        end
      end
      S_PUT: begin
        op        = OP_INS_PUT;
        state_nxt = after_ins;
      end
      S_GRP0: begin
        op        = OP_GRP_START;
        state_nxt = S_GRP;
      end
      S_GRP: begin
        op        = OP_GRP_STEP;
        state_nxt = st.i_done ? S_FLUSH : S_GRP;
      end
      S_FLUSH: begin
        op        = OP_GRP_FLUSH;
        state_nxt = S_RDI;
      end
      S_RDI: begin
        op        = OP_DP_RDI;
        state_nxt = S_TRRD;
      end
      S_TRRD: begin
        op        = OP_DP_TRRD;
        state_nxt = S_TRSTEP;
      end
      S_TRSTEP: begin
        op        = OP_DP_TRSTEP;
        state_nxt = st.adv ? S_TRSTEP : S_SUM;
      end
      S_SUM: begin
        op        = OP_DP_SUM;
        state_nxt = st.dp_last ? S_DONE : S_RDI;
      end
      S_DONE: begin
        op        = OP_FINISH;
        state_nxt = st.out_busy ? S_DONE : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/msvgs_dp.sv =====
// Datapath: value, count and best-sum memories, counters and arithmetic.
module msvgs_dp #(
  parameter int MAX_ITEMS = msvgs_pkg::MAX_ITEMS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  msvgs_pkg::op_t                op,
  input  logic [msvgs_pkg::VALUE_W-1:0] in_value,
  input  logic                          in_last,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [msvgs_pkg::TOTAL_W-1:0] out_total,
  output msvgs_pkg::status_t            st
);
  import msvgs_pkg::*;

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);

  logic [VALUE_W-1:0] v_r, v_nxt, cur_val_r, cur_val_nxt, vi_r, vi_nxt;
  logic               last_r, last_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt, j_r, j_nxt, i_r, i_nxt, g_r, g_nxt;
  logic [CW-1:0]      cur_cnt_r, cur_cnt_nxt, ci_r, ci_nxt;
  logic [AW-1:0]      trail_r, trail_nxt;
  logic [TOTAL_W-1:0] prod_r, prod_nxt, prev_r, prev_nxt, tot_r, tot_nxt;
  logic               ov_r, ov_nxt;

  logic               v_we, c_we, b_we;
  logic [AW-1:0]      v_wa, v_ra, c_wa, c_ra, b_wa, b_ra;
  logic [VALUE_W-1:0] v_wd, v_rd;
  logic [CW-1:0]      c_wd, c_rd;
  logic [TOTAL_W-1:0] b_wd, b_rd;

  logic [CW-1:0]      trail_ext;
  logic [TOTAL_W-1:0] take, cur;

  msvgs_ram #(.W(VALUE_W), .D(MAX_ITEMS)) u_val (
    .clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(v_rd)
  );
  msvgs_ram #(.W(CW), .D(MAX_ITEMS)) u_cnt (
    .clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd)
  );
  msvgs_ram #(.W(TOTAL_W), .D(MAX_ITEMS)) u_best (
    .clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd)
  );

  assign trail_ext = CW'(trail_r);
  assign take      = prod_r + ((trail_r != '0) ? b_rd : '0);
  assign cur       = (take > prev_r) ? take : prev_r;

  assign st.full     = (cnt_r == CW'(MAX_ITEMS));
  assign st.last     = last_r;
  assign st.j_zero   = (j_r == '0);
  assign st.j_one    = (j_r == CW'(1));
  assign st.gt       = (v_rd > v_r);
  assign st.i_done   = (i_r == cnt_r);
  assign st.adv      = ((trail_ext + CW'(1)) < g_r) &&
                       (({1'b0, v_rd} + (VALUE_W+1)'(GAP)) < {1'b0, vi_r});
  assign st.dp_last  = ((i_r + CW'(1)) == g_r);
  assign st.out_busy = ov_r && !out_ready;

  assign out_valid = ov_r;
  assign out_total = tot_r;

  always_comb begin
    v_nxt = v_r;  last_nxt = last_r;  cnt_nxt = cnt_r;  j_nxt = j_r;
    i_nxt = i_r;  g_nxt = g_r;  cur_val_nxt = cur_val_r;  cur_cnt_nxt = cur_cnt_r;
    vi_nxt = vi_r;  ci_nxt = ci_r;  trail_nxt = trail_r;  prod_nxt = prod_r;
    prev_nxt = prev_r;  tot_nxt = tot_r;
    ov_nxt = ov_r && !out_ready;
    v_we = 1'b0;  v_wa = j_r[AW-1:0];  v_wd = v_r;  v_ra = '0;
    c_we = 1'b0;  c_wa = g_r[AW-1:0];  c_wd = cur_cnt_r;  c_ra = i_r[AW-1:0];
    b_we = 1'b0;  b_wa = i_r[AW-1:0];  b_wd = cur;  b_ra = '0;
    case (op)
      OP_LOAD: begin
        v_nxt    = in_value;
        last_nxt = in_last;
        j_nxt    = cnt_r;
      end
      OP_INS_START: begin
        if (j_r == '0) begin
          v_we    = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
        end else begin
          v_ra = AW'(j_r - CW'(1));
        end
      end
      OP_INS_SHIFT: begin
        v_we = 1'b1;
        if (v_rd > v_r) begin
          v_wd  = v_rd;
          j_nxt = j_r - CW'(1);
          v_ra  = AW'(j_r - CW'(2));
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      OP_INS_PUT: begin
        v_we    = 1'b1;
        cnt_nxt = cnt_r + CW'(1);
      end
      OP_GRP_START: begin
        v_ra  = '0;
        i_nxt = CW'(1);
        g_nxt = '0;
      end
      OP_GRP_STEP: begin
        v_wa = g_r[AW-1:0];
        v_wd = cur_val_r;
        if (i_r == CW'(1)) begin
          cur_val_nxt = v_rd;
          cur_cnt_nxt = CW'(1);
        end else if (v_rd == cur_val_r) begin
          cur_cnt_nxt = cur_cnt_r + CW'(1);
        end else begin
          v_we        = 1'b1;
          c_we        = 1'b1;
          g_nxt       = g_r + CW'(1);
          cur_val_nxt = v_rd;
          cur_cnt_nxt = CW'(1);
        end
        if (i_r != cnt_r) begin
          v_ra  = i_r[AW-1:0];
          i_nxt = i_r + CW'(1);
        end
      end
      OP_GRP_FLUSH: begin
        v_wa      = g_r[AW-1:0];
        v_wd      = cur_val_r;
        v_we      = 1'b1;
        c_we      = 1'b1;
        g_nxt     = g_r + CW'(1);
        i_nxt     = '0;
        trail_nxt = '0;
        prev_nxt  = '0;
      end
      OP_DP_RDI: begin
        v_ra = i_r[AW-1:0];
      end
      OP_DP_TRRD: begin
        vi_nxt = v_rd;
        ci_nxt = c_rd;
        v_ra   = trail_r;
      end
      OP_DP_TRSTEP: begin
        if (st.adv) begin
          trail_nxt = trail_r + AW'(1);
          v_ra      = trail_r + AW'(1);
        end else begin
          b_ra     = trail_r - AW'(1);
          prod_nxt = TOTAL_W'(vi_r) * TOTAL_W'(ci_r);
        end
      end
      OP_DP_SUM: begin
        b_we     = 1'b1;
        prev_nxt = cur;
        i_nxt    = i_r + CW'(1);
      end
      OP_FINISH: begin
        if (!st.out_busy) begin
          ov_nxt  = 1'b1;
          tot_nxt = prev_r;
          cnt_nxt = '0;
        end
      end
      default: begin
        v_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      trail_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      trail_r <= trail_nxt;
      ov_r    <= ov_nxt;
    end
    v_r       <= v_nxt;
    last_r    <= last_nxt;
    j_r       <= j_nxt;
    i_r       <= i_nxt;
    g_r       <= g_nxt;
    cur_val_r <= cur_val_nxt;
    cur_cnt_r <= cur_cnt_nxt;
    vi_r      <= vi_nxt;
    ci_r      <= ci_nxt;
    prod_r    <= prod_nxt;
    prev_r    <= prev_nxt;
    tot_r     <= tot_nxt;
  end

endmodule

// ===== dv/max_sum_value_gap_selection_test.sv =====
// Testbench for the gap-of-two best total block: directed table, random sets, scoreboard.
module max_sum_value_gap_selection_test;
  import msvgs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = MAX_ITEMS_DEF;
  localparam longint CYCLE_LIMIT = 64'd40_000_000;

  typedef struct {
    logic [VALUE_W-1:0] pv;
    logic               lst;
    logic               chk;
    logic [TOTAL_W-1:0] total;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  msvgs_in_if  in_ch ();
  msvgs_out_if out_ch ();

  max_sum_value_gap_selection i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  logic [VALUE_W-1:0] set_values[$];
  logic [TOTAL_W-1:0] pending_totals[$];
  logic [TOTAL_W-1:0] typed_totals[$];
  logic               typed_flags[$];
  int  fail_count = 0;
  int  send_idle = 0;
  int  recv_idle = 0;
  longint cycles = 0;
  row_t rows[$];

  function automatic logic [TOTAL_W-1:0] best_gap_total(input logic [VALUE_W-1:0] vals[$]);
    logic [VALUE_W-1:0] grp_val[$];
    longint unsigned    grp_cnt[$];
    longint unsigned    best_upto[$];
    longint unsigned    take, skip;
    int                 trail;
    vals.sort();
    foreach (vals[k]) begin
      if (grp_val.size() == 0 || vals[k] != grp_val[$]) begin
        grp_val = {grp_val, vals[k]};
        grp_cnt = {grp_cnt, 64'd1};
      end else begin
        grp_cnt[$] = grp_cnt[$] + 1;
      end
    end
    trail = 0;
    foreach (grp_val[g]) begin
      while (trail + 1 < grp_val.size() &&
             longint'(grp_val[trail]) + GAP < longint'(grp_val[g]))
        trail++;
      skip = (g == 0) ? 0 : best_upto[g-1];
      take = longint'(grp_val[g]) * grp_cnt[g];
      if (trail > 0) take += best_upto[trail-1];
      best_upto = {best_upto, ((take > skip) ? take : skip)};
    end
    return (best_upto.size() == 0) ? '0 : best_upto[$][TOTAL_W-1:0];
  endfunction

  task automatic transfer_value(input logic [VALUE_W-1:0] pv, input logic lst,
                                input logic chk, input logic [TOTAL_W-1:0] total);
    while ($urandom_range(99) < send_idle) @(posedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.power_value <= pv;
    in_ch.last_item   <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (set_values.size() < CAP) set_values = {set_values, pv};
    if (lst) begin
      pending_totals = {pending_totals, best_gap_total(set_values)};
      typed_totals   = {typed_totals, total};
      typed_flags    = {typed_flags, chk};
      set_values.delete();
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_set(input int n, input int span, input int base);
    for (int k = 0; k < n; k++)
      transfer_value(VALUE_W'(base + $urandom_range(span)), k == n - 1, 1'b0, '0);
  endtask

  task automatic random_phase(input int items);
    int sent, n, mode;
    sent = 0;
    while (sent < items) begin
      n = $urandom_range(1, 12);
      mode = $urandom_range(3);
      case (mode)
        0: random_set(n, 8, 0);
        1: random_set(n, 30, $urandom_range(20));
        2: random_set(n, 6, 32'h3FFF_FFF0);
        default: random_set(n, 32'h3FFF_FFFF, 0);
      endcase
      sent += n;
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("max_sum_value_gap_selection: mismatch");
      $finish;
    end
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_totals.size() == 0) begin
        $error("best_total: no result expected, got %0d", out_ch.best_total);
        fail_count++;
      end else begin
        if (out_ch.best_total !== pending_totals[0]) begin
          $error("best_total: expected %0d, actual %0d", pending_totals[0],
                 out_ch.best_total);
          fail_count++;
        end
        if (typed_flags[0] && out_ch.best_total !== typed_totals[0]) begin
          $error("best_total: expected %0d, actual %0d", typed_totals[0],
                 out_ch.best_total);
          fail_count++;
        end
        void'(pending_totals.pop_front());
        void'(typed_totals.pop_front());
        void'(typed_flags.pop_front());
      end
    end
  end

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.power_value = '0;
    in_ch.last_item   = 1'b0;
    // pv, last, typed, total
    rows = '{
      '{30'd0, 1'b1, 1'b1, 41'd0},
      '{30'h3FFF_FFFF, 1'b1, 1'b1, 41'h3FFF_FFFF},
      '{30'd5, 1'b0, 1'b0, 41'd0},
      '{30'd5, 1'b1, 1'b1, 41'd10},
      '{30'd1, 1'b0, 1'b0, 41'd0},
      '{30'd3, 1'b1, 1'b1, 41'd3},
      '{30'd1, 1'b0, 1'b0, 41'd0},
      '{30'd4, 1'b1, 1'b1, 41'd5},
      '{30'd9, 1'b0, 1'b0, 41'd0},
      '{30'd2, 1'b0, 1'b0, 41'd0},
      '{30'd7, 1'b0, 1'b0, 41'd0},
      '{30'd2, 1'b0, 1'b0, 41'd0},
      '{30'd8, 1'b0, 1'b0, 41'd0},
      '{30'd3, 1'b1, 1'b0, 41'd0},
      '{30'h2AAA_AAAA, 1'b0, 1'b0, 41'd0},
      '{30'h1555_5555, 1'b0, 1'b0, 41'd0},
      '{30'h3FFF_FFFE, 1'b1, 1'b0, 41'd0}
    };
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[r]) transfer_value(rows[r].pv, rows[r].lst, rows[r].chk, rows[r].total);
    // overfill storage with the largest value: excess transfers are dropped
    for (int k = 0; k < CAP + 4; k++)
      transfer_value(30'h3FFF_FFFF, k == CAP + 3, 1'b1, 41'h3FFF_FFFF * 41'd1024);
    send_idle = 10; recv_idle = 46;
    random_phase(35);
    // hold until every result has arrived
    while (pending_totals.size() != 0) @(posedge clk);
    send_idle = 46; recv_idle = 10;
    random_phase(35);
    send_idle = 0; recv_idle = 0;
    random_phase(35);
    while (pending_totals.size() != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
    if (fail_count == 0 && pending_totals.size() == 0) begin
      $display("max_sum_value_gap_selection: match");
    end else begin
      $display("max_sum_value_gap_selection: mismatch");
    end
    $finish;
  end
endmodule
